// ----- sv/threshold_perceptron_inference_macros.svh -----
// assertion macros shared by the perceptron inference rtl
`ifndef THRESHOLD_PERCEPTRON_INFERENCE_MACROS_SVH
`define THRESHOLD_PERCEPTRON_INFERENCE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TPI_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpi: same-cycle check failed");
// next-cycle implication
`define TPI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpi: next-cycle check failed");
`else
`define TPI_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define TPI_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- sv/tpi_pkg.sv -----
// shared types and constants of the perceptron inference block
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

  // widths fixed by the port fields
  localparam int COMMAND_W   = 2;
  localparam int LEVEL_IN_W  = 2;
  localparam int NEURON_IN_W = 4;
  localparam int VALUE_IN_W  = 16;
  localparam int OUT_BITS_W  = 16;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  // neuron index carried down the datapath, wide enough for the largest array
  localparam int TAG_IDX_W = 6;

  // commands
  localparam logic [COMMAND_W-1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_BIAS    = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_ELEMENT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_INPUT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LEVEL_ONE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LEVEL_TWO   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LEVEL_THREE = 3'd4;

  // configuration reset values
  localparam logic [1:0]         RST_LEVEL_COUNT      = 2'd2;
  localparam logic [COUNT_W-1:0] RST_SIZE_INPUT       = 5'd5;
  localparam logic [COUNT_W-1:0] RST_SIZE_LEVEL_ONE   = 5'd6;
  localparam logic [COUNT_W-1:0] RST_SIZE_LEVEL_TWO   = 5'd4;
  localparam logic [COUNT_W-1:0] RST_SIZE_LEVEL_THREE = 5'd4;

  // control travelling with each product slot
  typedef struct packed {
    logic                 valid;
    logic                 first;   // first product of a neuron
    logic                 last;    // last product of a neuron
    logic                 none;    // neuron with no inputs, product is zero
    logic                 mul;     // first level, element times weight
    logic                 act;     // later levels, source neuron fired
    logic [TAG_IDX_W-1:0] index;   // destination neuron
  } tpi_tag_t;

  // neuron decision coming back from the datapath
  typedef struct packed {
    logic                 valid;
    logic                 fire;
    logic [TAG_IDX_W-1:0] index;
  } tpi_fire_t;

endpackage

`default_nettype wire

// ----- sv/tpi_mac.sv -----
// product, saturating accumulate and bias compare of one neuron at a time
`timescale 1ns / 1ps
`default_nettype none

module tpi_mac #(
  parameter int VALUE_WIDTH = 16,
  parameter int FRAC_BITS   = 12
) (
  input  wire                            clk,
  input  wire                            rst,
  input  tpi_pkg::tpi_tag_t              tag,
  input  wire logic signed [VALUE_WIDTH-1:0] x,
  input  wire logic signed [VALUE_WIDTH-1:0] w,
  input  wire logic signed [VALUE_WIDTH-1:0] b,
  output tpi_pkg::tpi_fire_t             fire,
  output logic                           busy
);
  import tpi_pkg::*;

  // accumulator, threshold, product, sum and compare widths
  localparam int AW = 2 * VALUE_WIDTH;
  localparam int TW = VALUE_WIDTH + FRAC_BITS;
  localparam int PW = (AW > TW) ? AW : TW;
  localparam int SW = PW + 1;
  localparam int KW = (AW > TW) ? AW : TW;

  localparam logic signed [SW-1:0] ACC_HI = SW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

  logic signed [AW-1:0] mul_full;
  logic signed [PW-1:0] w_ext;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] prod;
  logic signed [VALUE_WIDTH-1:0] p_bias;
  tpi_tag_t             p_tag;

  logic signed [SW-1:0] base;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] clamped;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_next;
  logic signed [KW-1:0] acc_cmp;
  logic signed [KW-1:0] thr;

  // product select: element times weight, weight scaled by a fired neuron, or zero
  assign mul_full = x * w;
  always_comb begin
    w_ext = PW'(w);
    if (tag.none) begin
      prod_next = '0;
    end else if (tag.mul) begin
      prod_next = PW'(mul_full);
    end else if (tag.act) begin
      prod_next = w_ext <<< FRAC_BITS;
    end else begin
      prod_next = '0;
    end
  end

  // product stage register
  always_ff @(posedge clk) begin
    p_tag  <= tag;
    prod   <= prod_next;
    p_bias <= b;
    if (rst) begin
      p_tag.valid <= 1'b0;
    end
  end

  // saturating add and strict compare against the scaled bias
  always_comb begin
    base = p_tag.first ? '0 : SW'(acc);
    sum  = base + SW'(prod);
    if (sum > ACC_HI) begin
      clamped = ACC_HI;
    end else if (sum < ACC_LO) begin
      clamped = ACC_LO;
    end else begin
      clamped = sum;
    end
    acc_next = AW'(clamped);
    acc_cmp  = KW'(acc_next);
    thr      = KW'(p_bias) <<< FRAC_BITS;
  end

  // accumulate stage register and decision
  always_ff @(posedge clk) begin
    if (p_tag.valid) begin
      acc <= acc_next;
    end
    fire.fire  <= acc_cmp > thr;
    fire.index <= p_tag.index;
    if (rst) begin
      fire.valid <= 1'b0;
    end else begin
      fire.valid <= p_tag.valid & p_tag.last;
    end
  end

  assign busy = p_tag.valid | fire.valid;

endmodule

`default_nettype wire

// ----- sv/threshold_perceptron_inference.sv -----
// Step-activation perceptron inference. Each input item is one command: weight write,
// bias write or input element, taken only while the block is idle. An element with
// last set starts an inference that yields one result item; a count mismatch skips
// the levels and yields the error result from the finish state. Inference reads one
// weight per cycle from the weight memory, so a level with Nin inputs and Nout neurons
// issues Nout * max(Nin, 1) products and then drains the datapath; the reset sizes are
// 5-6-4. Input stall is high from the start of an inference until its result is issued.
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_perceptron_inference_macros.svh"

module threshold_perceptron_inference #(
  parameter int MAX_LEVELS  = 3,
  parameter int MAX_NEURONS = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int FRAC_BITS   = 12
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_write,
  input  wire [tpi_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire [tpi_pkg::CFG_DATA_W-1:0]         cfg_data,
  // command items
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire [tpi_pkg::COMMAND_W-1:0]          command,
  input  wire [tpi_pkg::LEVEL_IN_W-1:0]         level_index,
  input  wire [tpi_pkg::NEURON_IN_W-1:0]        from_index,
  input  wire [tpi_pkg::NEURON_IN_W-1:0]        to_index,
  input  wire logic signed [tpi_pkg::VALUE_IN_W-1:0] value,
  input  wire                                   last,
  // result items
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [tpi_pkg::OUT_BITS_W-1:0]        output_bits,
  output logic                                  size_error
);
  import tpi_pkg::*;

  localparam int NSQ     = MAX_NEURONS * MAX_NEURONS;
  localparam int W_DEPTH = MAX_LEVELS * NSQ;
  localparam int B_DEPTH = MAX_LEVELS * MAX_NEURONS;
  localparam int WA      = $clog2(W_DEPTH);
  localparam int BA      = $clog2(B_DEPTH);
  localparam int NW      = $clog2(MAX_NEURONS);
  localparam int CW      = $clog2(MAX_NEURONS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH} state_t;

  // configuration registers
  logic [1:0]         level_count;
  logic [COUNT_W-1:0] size_input;
  logic [COUNT_W-1:0] size_level_one;
  logic [COUNT_W-1:0] size_level_two;
  logic [COUNT_W-1:0] size_level_three;

  // control
  state_t              state;
  logic [COUNT_W-1:0]  element_count;
  logic [COUNT_W-1:0]  count_next;
  logic [1:0]          lvl;
  logic [NW-1:0]       i;
  logic [NW-1:0]       j;
  logic [MAX_NEURONS-1:0] cur_bits;
  logic [MAX_NEURONS-1:0] nxt_bits;
  logic [OUT_BITS_W-1:0]  result_bits;
  logic [OUT_BITS_W-1:0]  final_bits;
  logic [63:0]            nxt_wide;
  logic                   err;

  // derived sizes
  logic [1:0]    lc;
  logic [1:0]    levels;
  logic [CW-1:0] sz_in;
  logic [CW-1:0] sz_l1;
  logic [CW-1:0] sz_l2;
  logic [CW-1:0] sz_l3;
  logic [CW-1:0] in_size;
  logic [CW-1:0] out_size;
  logic          last_j;
  logic          last_i;
  logic          issue;
  logic          accept;
  logic          mismatch;

  // stores
  logic signed [VALUE_WIDTH-1:0] weight_mem [W_DEPTH];
  logic signed [VALUE_WIDTH-1:0] bias_mem [B_DEPTH];
  logic signed [VALUE_WIDTH-1:0] input_mem [MAX_NEURONS];
  logic signed [VALUE_WIDTH-1:0] w_rdata;
  logic signed [VALUE_WIDTH-1:0] b_rdata;
  logic signed [VALUE_WIDTH-1:0] x_rdata;
  logic signed [31:0]            value_ext;
  logic signed [VALUE_WIDTH-1:0] value_v;
  logic [WA-1:0] w_waddr;
  logic [WA-1:0] w_raddr;
  logic [BA-1:0] b_waddr;
  logic [BA-1:0] b_raddr;
  logic [NW-1:0] x_waddr;
  logic          w_we;
  logic          b_we;
  logic          x_we;
  logic          lvl_ok;
  logic          from_ok;
  logic          to_ok;

  // datapath handshake
  tpi_tag_t  s1_tag;
  tpi_fire_t fire;
  logic      mac_busy;

  function automatic logic [CW-1:0] clamp_size(input logic [COUNT_W-1:0] s);
    return (32'(s) > MAX_NEURONS) ? CW'(MAX_NEURONS) : CW'(s);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count      <= RST_LEVEL_COUNT;
      size_input       <= RST_SIZE_INPUT;
      size_level_one   <= RST_SIZE_LEVEL_ONE;
      size_level_two   <= RST_SIZE_LEVEL_TWO;
      size_level_three <= RST_SIZE_LEVEL_THREE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEVEL_COUNT:      level_count      <= cfg_data[1:0];
        REG_SIZE_INPUT:       size_input       <= cfg_data;
        REG_SIZE_LEVEL_ONE:   size_level_one   <= cfg_data;
        REG_SIZE_LEVEL_TWO:   size_level_two   <= cfg_data;
        REG_SIZE_LEVEL_THREE: size_level_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // level count and neuron counts after clamping
  always_comb begin
    lc     = (level_count == 2'd0) ? 2'd1 : level_count;
    levels = (32'(lc) > MAX_LEVELS) ? 2'(MAX_LEVELS) : lc;
    sz_in  = clamp_size(size_input);
    sz_l1  = clamp_size(size_level_one);
    sz_l2  = clamp_size(size_level_two);
    sz_l3  = clamp_size(size_level_three);
    unique case (lvl)
      2'd0: begin
        in_size  = sz_in;
        out_size = sz_l1;
      end
      2'd1: begin
        in_size  = sz_l1;
        out_size = sz_l2;
      end
      default: begin
        in_size  = sz_l2;
        out_size = sz_l3;
      end
    endcase
  end

  // sequencer position
  assign last_j = (in_size == '0) || (32'(j) + 1 >= 32'(in_size));
  assign last_i = 32'(i) + 1 >= 32'(out_size);
  assign issue  = (state == ST_RUN) && (out_size != '0);

  // command decode
  assign in_stall   = state != ST_IDLE;
  assign accept     = in_valid && !in_stall;
  assign value_ext  = 32'(value);
  assign value_v    = value_ext[VALUE_WIDTH-1:0];
  assign lvl_ok     = 32'(level_index) < MAX_LEVELS;
  assign from_ok    = 32'(from_index) < MAX_NEURONS;
  assign to_ok      = 32'(to_index) < MAX_NEURONS;
  assign w_we       = accept && (command == CMD_WEIGHT) && lvl_ok && from_ok && to_ok;
  assign b_we       = accept && (command == CMD_BIAS) && lvl_ok && to_ok;
  assign x_we       = accept && (command == CMD_ELEMENT) && from_ok;
  assign w_waddr    = WA'(32'(level_index) * NSQ + 32'(from_index) * MAX_NEURONS
                          + 32'(to_index));
  assign b_waddr    = BA'(32'(level_index) * MAX_NEURONS + 32'(to_index));
  assign x_waddr    = NW'(32'(from_index));
  assign count_next = (element_count == '1) ? element_count : element_count + 1'b1;
  assign mismatch   = 32'(count_next) != 32'(sz_in);

  // read addresses for the current product
  assign w_raddr = WA'(32'(lvl) * NSQ + 32'(j) * MAX_NEURONS + 32'(i));
  assign b_raddr = BA'(32'(lvl) * MAX_NEURONS + 32'(i));

  // stores: writes only while idle; read data is used only while running
  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= value_v;
    end
    w_rdata <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[b_waddr] <= value_v;
    end
    b_rdata <= bias_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      input_mem[x_waddr] <= value_v;
    end
    x_rdata <= input_mem[j];
  end

  // slot control aligned with the memory read data
  always_ff @(posedge clk) begin
    s1_tag.first <= (j == '0);
    s1_tag.last  <= last_j;
    s1_tag.none  <= (in_size == '0);
    s1_tag.mul   <= (lvl == 2'd0);
    s1_tag.act   <= cur_bits[j];
    s1_tag.index <= TAG_IDX_W'(i);
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= issue;
    end
  end

  tpi_mac #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .tag  (s1_tag),
    .x    (x_rdata),
    .w    (w_rdata),
    .b    (b_rdata),
    .fire (fire),
    .busy (mac_busy)
  );

  // final level bits as the result word
  assign nxt_wide   = 64'(nxt_bits);
  assign final_bits = nxt_wide[OUT_BITS_W-1:0];

  // main state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_count <= '0;
      out_valid     <= 1'b0;
      lvl           <= '0;
      i             <= '0;
      j             <= '0;
      err           <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire.valid) begin
        nxt_bits[NW'(fire.index)] <= fire.fire;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_ELEMENT)) begin
            if (last) begin
              element_count <= '0;
              lvl           <= '0;
              i             <= '0;
              j             <= '0;
              nxt_bits      <= '0;
              if (mismatch) begin
                err         <= 1'b1;
                result_bits <= '0;
                state       <= ST_FINISH;
              end else begin
                err   <= 1'b0;
                state <= ST_RUN;
              end
            end else begin
              element_count <= count_next;
            end
          end
        end
        ST_RUN: begin
          if (out_size == '0) begin
            state <= ST_DRAIN;
          end else if (last_j) begin
            j <= '0;
            if (last_i) begin
              i     <= '0;
              state <= ST_DRAIN;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_DRAIN: begin
          // level complete once no slot is left in flight
          if (!s1_tag.valid && !mac_busy) begin
            cur_bits <= nxt_bits;
            nxt_bits <= '0;
            if (32'(lvl) + 1 >= 32'(levels)) begin
              result_bits <= final_bits;
              state       <= ST_FINISH;
            end else begin
              lvl   <= lvl + 1'b1;
              state <= ST_RUN;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            output_bits <= result_bits;
            size_error  <= err;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `TPI_ASSERT_IMPLY(a_fire_in_work, clk, rst, fire.valid, (state == ST_RUN) || (state == ST_DRAIN))
  `TPI_ASSERT_NEXT(a_drain_waits, clk, rst, (state == ST_DRAIN) && (s1_tag.valid || mac_busy), state == ST_DRAIN)
  `TPI_ASSERT_IMPLY(a_error_clears_bits, clk, rst, out_valid && size_error, output_bits == '0)
  `TPI_ASSERT_IMPLY(a_count_clear_busy, clk, rst, state != ST_IDLE, element_count == '0)
  `TPI_ASSERT_IMPLY(a_result_from_finish, clk, rst, $rose(out_valid), $past(state) == ST_FINISH)

endmodule

`default_nettype wire
